// ===== rtl/core/rmwq_pkg.sv =====
// Shared definitions for the recursive mutex waiter queue.
// Request and result codes and the cell control struct; no dependencies.
`default_nettype none

package rmwq_pkg;

    // Request function codes
    localparam logic [1:0] FN_ACQUIRE = 2'd0;
    localparam logic [1:0] FN_RELEASE = 2'd1;
    localparam logic [1:0] FN_CANCEL  = 2'd2;

    // Result status codes
    localparam logic [3:0] ST_GRANTED  = 4'd0;
    localparam logic [3:0] ST_RAISED   = 4'd1;
    localparam logic [3:0] ST_REFUSED  = 4'd2;
    localparam logic [3:0] ST_QUEUED   = 4'd3;
    localparam logic [3:0] ST_QFULL    = 4'd4;
    localparam logic [3:0] ST_STILL    = 4'd5;
    localparam logic [3:0] ST_FREED    = 4'd6;
    localparam logic [3:0] ST_HANDED   = 4'd7;
    localparam logic [3:0] ST_NOTHELD  = 4'd8;
    localparam logic [3:0] ST_NOTOWNER = 4'd9;
    localparam logic [3:0] ST_DETAIL   = 4'd10;

    // Detail codes for ST_DETAIL
    localparam logic [1:0] DT_CANCELLED = 2'd0;
    localparam logic [1:0] DT_NOTFOUND  = 2'd1;
    localparam logic [1:0] DT_CNTFULL   = 2'd2;

    // Per-cycle control broadcast to every queue cell
    typedef struct packed {
        logic push;    // append key at the first free cell
        logic pop;     // remove the head cell
        logic cancel;  // remove the oldest cell matching key
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/rmwq_cell.sv =====
// One slot of the waiter queue: valid bit and waiter id.
// Shifts from its downstream neighbor on removal; uses rmwq_pkg.
`default_nettype none

module rmwq_cell #(
    parameter int ID_BITS = 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  rmwq_pkg::t_cell_ctrl   i_ctrl,
    input  wire  [ID_BITS-1:0]     i_key,
    input  wire                    i_prefix,     // removal point is upstream
    input  wire                    i_prev_valid, // upstream cell occupied
    input  wire                    i_next_valid,
    input  wire  [ID_BITS-1:0]     i_next_id,
    output logic                   o_prefix,
    output logic                   o_valid,
    output logic [ID_BITS-1:0]     o_id
);
    import rmwq_pkg::*;

    logic               r_valid;
    logic [ID_BITS-1:0] r_id;
    logic               w_match;
    logic               w_shift;
    logic               w_load;

    // Cancel match, and shift when the removal point is here or upstream
    assign w_match  = i_ctrl.cancel && r_valid && (r_id == i_key);
    assign w_shift  = i_prefix || w_match;
    assign w_load   = i_ctrl.push && !r_valid && i_prev_valid;
    assign o_prefix = w_shift;
    assign o_valid  = r_valid;
    assign o_id     = r_id;

    // Occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_next_valid;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end
    end

    // Waiter id, no reset
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_id <= i_next_id;
        end else if (w_load) begin
            r_id <= i_key;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/recursive_mutex_waiter_queue_unit.sv =====
// A request accepted at a clock edge moves through the execute cycle and then
// the registered result cycle, which drives the result strobe.
// No new request is taken while busy; busy is high for the execute cycle.
// The execute cycle resolves the lock and updates the row of queue cells.
// Reset (synchronous, active low): lock free, queue empty, recursive mode on.
// Results cannot be stalled; each is shown for one cycle on o_valid.
`default_nettype none

module recursive_mutex_waiter_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int COUNT_BITS  = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_wdata,
    input  wire                 start,
    output logic                busy,
    input  wire  [1:0]          i_func,
    input  wire  [ID_BITS-1:0]  i_requester,
    input  wire                 i_blocking,
    output logic                o_valid,
    output logic [3:0]          o_status,
    output logic [1:0]          o_detail,
    output logic [ID_BITS-1:0]  o_new_owner,
    output logic                o_handoff
);
    import rmwq_pkg::*;

    // Configuration and lock state
    logic                  r_rec;
    logic                  r_held,  n_held;
    logic [ID_BITS-1:0]    r_owner, n_owner;
    logic [COUNT_BITS-1:0] r_hold,  n_hold;

    // Captured request
    logic                  r_exec;
    logic [1:0]            r_func;
    logic [ID_BITS-1:0]    r_who;
    logic                  r_blk;

    // Result registers
    logic                  r_valid;
    logic [3:0]            r_status, n_status;
    logic [1:0]            r_detail, n_detail;
    logic [ID_BITS-1:0]    r_nown,   n_nown;
    logic                  r_hand,   n_hand;

    // Cell row
    t_cell_ctrl            w_ctrl;
    logic                  w_push, w_pop;
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_prefix;
    logic [ID_BITS-1:0]    w_id [QUEUE_DEPTH];
    logic                  w_empty, w_full, w_found;

    assign busy        = r_exec;
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_detail    = r_detail;
    assign o_new_owner = r_nown;
    assign o_handoff   = r_hand;

    assign w_empty = !w_valid[0];
    assign w_full  = w_valid[QUEUE_DEPTH-1];
    assign w_found = w_prefix[QUEUE_DEPTH-1];

    assign w_ctrl.push   = r_exec && w_push;
    assign w_ctrl.pop    = r_exec && w_pop;
    assign w_ctrl.cancel = r_exec && (r_func == FN_CANCEL);

    // Queue cells, head at index 0
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        logic               w_pin;
        logic               w_prev;
        logic               w_nv;
        logic [ID_BITS-1:0] w_nid;
        if (k == 0) begin : g_head
            assign w_pin  = w_ctrl.pop;
            assign w_prev = 1'b1;
        end else begin : g_body
            assign w_pin  = w_prefix[k-1];
            assign w_prev = w_valid[k-1];
        end
        if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign w_nv  = 1'b0;
            assign w_nid = '0;
        end else begin : g_link
            assign w_nv  = w_valid[k+1];
            assign w_nid = w_id[k+1];
        end
        rmwq_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_key        (r_who),
            .i_prefix     (w_pin),
            .i_prev_valid (w_prev),
            .i_next_valid (w_nv),
            .i_next_id    (w_nid),
            .o_prefix     (w_prefix[k]),
            .o_valid      (w_valid[k]),
            .o_id         (w_id[k])
        );
    end

    // Request decision
    always_comb begin
        n_held   = r_held;
        n_owner  = r_owner;
        n_hold   = r_hold;
        n_status = ST_DETAIL;
        n_detail = DT_NOTFOUND;
        n_nown   = '0;
        n_hand   = 1'b0;
        w_push   = 1'b0;
        w_pop    = 1'b0;
        case (r_func)
            FN_ACQUIRE: begin
                n_detail = DT_CANCELLED;
                if (!r_held && w_empty) begin
                    n_held   = 1'b1;
                    n_owner  = r_who;
                    n_hold   = COUNT_BITS'(1);
                    n_status = ST_GRANTED;
                    n_nown   = r_who;
                end else if (r_rec && r_held && (r_who == r_owner)) begin
                    if (&r_hold) begin
                        n_status = ST_DETAIL;
                        n_detail = DT_CNTFULL;
                    end else begin
                        n_hold   = r_hold + COUNT_BITS'(1);
                        n_status = ST_RAISED;
                        n_nown   = r_owner;
                    end
                end else if (!r_blk) begin
                    n_status = ST_REFUSED;
                end else if (w_full) begin
                    n_status = ST_QFULL;
                end else begin
                    w_push   = 1'b1;
                    n_status = ST_QUEUED;
                end
            end
            FN_RELEASE: begin
                n_detail = DT_CANCELLED;
                if (!r_held) begin
                    n_status = ST_NOTHELD;
                end else if (r_rec && (r_who != r_owner)) begin
                    n_status = ST_NOTOWNER;
                end else if (r_rec && (r_hold > COUNT_BITS'(1))) begin
                    n_hold   = r_hold - COUNT_BITS'(1);
                    n_status = ST_STILL;
                    n_nown   = r_owner;
                end else if (!w_empty) begin
                    // hand the lock to the oldest waiter
                    n_owner  = w_id[0];
                    n_hold   = COUNT_BITS'(1);
                    w_pop    = 1'b1;
                    n_status = ST_HANDED;
                    n_nown   = w_id[0];
                    n_hand   = 1'b1;
                end else begin
                    n_held   = 1'b0;
                    n_owner  = '0;
                    n_hold   = '0;
                    n_status = ST_FREED;
                end
            end
            FN_CANCEL: begin
                n_detail = w_found ? DT_CANCELLED : DT_NOTFOUND;
            end
            default: begin
                n_detail = DT_NOTFOUND;
            end
        endcase
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec <= 1'b1;
        end else if (i_cfg_we) begin
            r_rec <= i_cfg_wdata;
        end
    end

    // Control: execute flag, lock state, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec  <= 1'b0;
            r_valid <= 1'b0;
            r_held  <= 1'b0;
            r_owner <= '0;
            r_hold  <= '0;
        end else begin
            r_exec  <= start && !r_exec;
            r_valid <= r_exec;
            if (r_exec) begin
                r_held  <= n_held;
                r_owner <= n_owner;
                r_hold  <= n_hold;
            end
        end
    end

    // Request capture and result payload
    always_ff @(posedge i_clk) begin
        if (start && !r_exec) begin
            r_func <= i_func;
            r_who  <= i_requester;
            r_blk  <= i_blocking;
        end
        if (r_exec) begin
            r_status <= n_status;
            r_detail <= n_detail;
            r_nown   <= n_nown;
            r_hand   <= n_hand;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rmwq_checker.sv =====
// Port-level checks for the recursive mutex waiter queue unit.
// Uses rmwq_pkg codes; bound to recursive_mutex_waiter_queue_unit.
`default_nettype none

module rmwq_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       start,
    input wire       busy,
    input wire       o_valid,
    input wire [3:0] o_status,
    input wire [1:0] o_detail,
    input wire       o_handoff
);
    import rmwq_pkg::*;

    // Every result strobe belongs to an earlier accepted request
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without a request");

    // An accepted request always produces a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("request lost");

    // Handoff flag only with a handoff status
    a_handoff_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_handoff) |-> (o_status == ST_HANDED))
        else $error("handoff flag on wrong status");

    // Detail is zero except for the detail status
    a_detail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_DETAIL)) |-> (o_detail == DT_CANCELLED))
        else $error("stray detail code");

endmodule

bind recursive_mutex_waiter_queue_unit rmwq_checker u_rmwq_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_valid   (o_valid),
    .o_status  (o_status),
    .o_detail  (o_detail),
    .o_handoff (o_handoff)
);

`default_nettype wire
